/* design/ttb_pkg.sv */
// Shared types and constants for the triangle tangent basis block.
// No dependencies; used by ttb_ctrl, ttb_dpath and triangle_tangent_basis.
package ttb_pkg;

    // Magnitudes are brought to this bit length before the square root
    localparam int NORM_BITS  = 30;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;
    localparam int NUM_CROSS  = 7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DET_ZERO = 2'd1,
        ST_VEC_ZERO = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CORNER,
        OP_TRI,
        OP_CROSS,
        OP_MAG,
        OP_LEN,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_STORE
    } t_op;

    // Controller to datapath
    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] cnt;
        logic             vsel;
        logic             corner_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic det_zero;
        logic vec_zero;
    } t_dstat;

endpackage

/* design/ttb_dpath.sv */
// Datapath: corner storage, cross products, normalization (square root, divide).
// Depends on ttb_pkg; driven by commands from ttb_ctrl.
module ttb_dpath #(
    parameter int COORD_BITS     = 16,
    parameter int UV_BITS        = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ttb_pkg::t_cmd                     i_cmd,
    input  logic signed [COORD_BITS-1:0]      i_pos_x,
    input  logic signed [COORD_BITS-1:0]      i_pos_y,
    input  logic signed [COORD_BITS-1:0]      i_pos_z,
    input  logic signed [UV_BITS-1:0]         i_tex_u,
    input  logic signed [UV_BITS-1:0]         i_tex_v,
    output ttb_pkg::t_dstat                   o_dstat,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_tan [3],
    output logic signed [UNIT_FRAC_BITS+1:0]  o_bit [3]
);

    localparam int MB = ((COORD_BITS > UV_BITS) ? COORD_BITS : UV_BITS) + 1;
    localparam int PW = 2 * MB;
    localparam int W  = PW + 1;
    localparam int LW = $clog2(W + 1);
    localparam int QB = UNIT_FRAC_BITS + 2;
    localparam int RW = ttb_pkg::NORM_BITS + 1;
    localparam int SW = W + ttb_pkg::NORM_BITS + 1;
    localparam int DW = ttb_pkg::ROOT_W + QB + 1;

    logic signed [COORD_BITS-1:0] pos [3];
    logic signed [COORD_BITS-1:0] r_cp [2][3];
    logic signed [UV_BITS-1:0]    r_ct [2][2];
    logic signed [COORD_BITS:0]   r_e1 [3];
    logic signed [COORD_BITS:0]   r_e2 [3];
    logic signed [UV_BITS:0]      r_d1 [2];
    logic signed [UV_BITS:0]      r_d2 [2];

    logic signed [MB-1:0] op_a, op_b, op_c, op_d;
    logic [1:0]           ix;
    logic signed [PW-1:0] r_pa, r_pb;
    logic [2:0]           r_pidx;
    logic                 r_pv;
    logic signed [W-1:0]  r_cr [ttb_pkg::NUM_CROSS];

    logic signed [W-1:0]  vec [3];
    logic [W-1:0]         r_mag [3];
    logic                 r_neg [3];
    logic [W-1:0]         mag_or;
    logic [LW-1:0]        len;
    logic [LW-1:0]        r_len;
    logic [RW-1:0]        r_r [3];
    logic [SW-1:0]        sh_in [3];
    logic [RW-1:0]        sq_op;
    logic [ttb_pkg::SUM_W-1:0] r_acc, r_s, r_root, sq_bit, sq_trial;
    logic [ttb_pkg::ROOT_W-1:0] r_n;
    logic [DW-1:0]        r_rem [3];
    logic [DW-1:0]        dv;
    logic [QB-1:0]        r_q [3];
    logic [QB-1:0]        r_to [3];
    logic [QB-1:0]        r_bo [3];
    logic                 flip;

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    assign flip = r_cr[0][W-1];
    assign o_dstat.det_zero = (r_cr[0] == '0);
    assign o_dstat.vec_zero = (r_len == '0);

    // Cross product operand select: determinant, tangent terms, bitangent terms
    always_comb begin
        ix = 2'd0;
        case (i_cmd.cnt[2:0])
            3'd1, 3'd4: ix = 2'd0;
            3'd2, 3'd5: ix = 2'd1;
            3'd3, 3'd6: ix = 2'd2;
            default:    ix = 2'd0;
        endcase
        if (i_cmd.cnt[2:0] == 3'd0) begin
            op_a = MB'(r_d1[0]);
            op_b = MB'(r_d2[1]);
            op_c = MB'(r_d2[0]);
            op_d = MB'(r_d1[1]);
        end else if (i_cmd.cnt[2:0] < 3'd4) begin
            op_a = MB'(r_d2[1]);
            op_b = MB'(r_e1[ix]);
            op_c = MB'(r_d1[1]);
            op_d = MB'(r_e2[ix]);
        end else begin
            op_a = MB'(r_d1[0]);
            op_b = MB'(r_e2[ix]);
            op_c = MB'(r_d2[0]);
            op_d = MB'(r_e1[ix]);
        end
    end

    // Vector under normalization and the bit length of its largest magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vec[i] = i_cmd.vsel ? r_cr[4+i] : r_cr[1+i];
        end
        mag_or = r_mag[0] | r_mag[1] | r_mag[2];
        len = '0;
        for (int j = 0; j < W; j++) begin
            if (mag_or[j]) len = LW'(j + 1);
        end
        for (int i = 0; i < 3; i++) begin
            sh_in[i] = SW'(r_mag[i]);
        end
        case (i_cmd.cnt[1:0])
            2'd1:    sq_op = r_r[1];
            2'd2:    sq_op = r_r[2];
            default: sq_op = r_r[0];
        endcase
        sq_bit   = ttb_pkg::SUM_W'(1) << {i_cmd.cnt, 1'b0};
        sq_trial = r_root + sq_bit;
        dv       = DW'(r_n) << i_cmd.cnt;
    end

    // Product pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (i_cmd.op == ttb_pkg::OP_CROSS);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_cr[r_pidx] <= W'(r_pa) - W'(r_pb);
        end
        case (i_cmd.op)
            ttb_pkg::OP_CORNER: begin
                for (int i = 0; i < 3; i++) r_cp[i_cmd.corner_sel][i] <= pos[i];
                r_ct[i_cmd.corner_sel][0] <= i_tex_u;
                r_ct[i_cmd.corner_sel][1] <= i_tex_v;
            end
            ttb_pkg::OP_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= (COORD_BITS+1)'(r_cp[1][i]) - (COORD_BITS+1)'(r_cp[0][i]);
                    r_e2[i] <= (COORD_BITS+1)'(pos[i]) - (COORD_BITS+1)'(r_cp[0][i]);
                end
                r_d1[0] <= (UV_BITS+1)'(r_ct[1][0]) - (UV_BITS+1)'(r_ct[0][0]);
                r_d1[1] <= (UV_BITS+1)'(r_ct[1][1]) - (UV_BITS+1)'(r_ct[0][1]);
                r_d2[0] <= (UV_BITS+1)'(i_tex_u) - (UV_BITS+1)'(r_ct[0][0]);
                r_d2[1] <= (UV_BITS+1)'(i_tex_v) - (UV_BITS+1)'(r_ct[0][1]);
            end
            ttb_pkg::OP_CROSS: begin
                r_pa   <= op_a * op_b;
                r_pb   <= op_c * op_d;
                r_pidx <= i_cmd.cnt[2:0];
            end
            ttb_pkg::OP_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= vec[i][W-1];
                    r_mag[i] <= vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
                end
            end
            ttb_pkg::OP_LEN: begin
                r_len <= len;
            end
            ttb_pkg::OP_SHIFT: begin
                // right shift truncates, left shift is exact
                for (int i = 0; i < 3; i++) begin
                    if (r_len > LW'(ttb_pkg::NORM_BITS)) begin
                        r_r[i] <= RW'(sh_in[i] >> (r_len - LW'(ttb_pkg::NORM_BITS)));
                    end else begin
                        r_r[i] <= RW'(sh_in[i] << (LW'(ttb_pkg::NORM_BITS) - r_len));
                    end
                end
            end
            ttb_pkg::OP_SQ: begin
                r_acc <= ((i_cmd.cnt == '0) ? '0 : r_acc)
                         + ttb_pkg::SUM_W'(sq_op * sq_op);
            end
            ttb_pkg::OP_SQRT_INIT: begin
                r_s    <= r_acc;
                r_root <= '0;
            end
            ttb_pkg::OP_SQRT: begin
                if (r_s >= sq_trial) begin
                    r_s    <= r_s - sq_trial;
                    r_root <= (r_root >> 1) + sq_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            ttb_pkg::OP_DIV_INIT: begin
                r_n <= r_root[ttb_pkg::ROOT_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= (DW'(r_r[i]) << UNIT_FRAC_BITS)
                                + DW'(r_root[ttb_pkg::ROOT_W-1:1]);
                    r_q[i]   <= '0;
                end
            end
            ttb_pkg::OP_DIV: begin
                // one quotient bit per cycle, three components side by side
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[i] >= dv) begin
                        r_rem[i] <= r_rem[i] - dv;
                        r_q[i]   <= r_q[i] | (QB'(1) << i_cmd.cnt);
                    end
                end
            end
            ttb_pkg::OP_STORE: begin
                for (int i = 0; i < 3; i++) begin
                    if (i_cmd.vsel) begin
                        r_bo[i] <= (r_neg[i] ^ flip) ? QB'(-r_q[i]) : r_q[i];
                    end else begin
                        r_to[i] <= (r_neg[i] ^ flip) ? QB'(-r_q[i]) : r_q[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_tan[i] = r_to[i];
            o_bit[i] = r_bo[i];
        end
    end

endmodule

/* design/ttb_ctrl.sv */
// Controller: vertex slot tracking and the per-triangle step sequence.
// Depends on ttb_pkg; commands ttb_dpath.
module ttb_ctrl #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mesh_start,
    input  ttb_pkg::t_dstat   i_dstat,
    input  logic              i_out_free,
    output ttb_pkg::t_cmd     o_cmd,
    output logic              o_emit,
    output ttb_pkg::t_status  o_code
);

    localparam int QB = UNIT_FRAC_BITS + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_CROSS, S_CWAIT, S_DCHK, S_MAG, S_LEN, S_LCHK, S_SHIFT,
        S_SQ, S_SQI, S_SQRT, S_DVI, S_DIV, S_STORE, S_EMIT
    } t_state;

    t_state                    r_state;
    logic [ttb_pkg::CNT_W-1:0] r_cnt;
    logic [1:0]                r_slot;
    logic                      r_vsel;
    ttb_pkg::t_status          r_code;
    logic                      fire;
    logic [1:0]                slot_eff;

    assign o_ready  = (r_state == S_IDLE);
    assign fire     = i_valid && o_ready;
    assign slot_eff = (i_mesh_start || r_slot == 2'd3) ? 2'd0 : r_slot;
    assign o_emit   = (r_state == S_EMIT) && i_out_free;
    assign o_code   = r_code;

    // Command decode
    always_comb begin
        o_cmd.op         = ttb_pkg::OP_NONE;
        o_cmd.cnt        = r_cnt;
        o_cmd.vsel       = r_vsel;
        o_cmd.corner_sel = slot_eff[0];
        unique case (r_state)
            S_IDLE:  if (fire) o_cmd.op = (slot_eff == 2'd2) ? ttb_pkg::OP_TRI
                                                              : ttb_pkg::OP_CORNER;
            S_CROSS: o_cmd.op = ttb_pkg::OP_CROSS;
            S_MAG:   o_cmd.op = ttb_pkg::OP_MAG;
            S_LEN:   o_cmd.op = ttb_pkg::OP_LEN;
            S_SHIFT: o_cmd.op = ttb_pkg::OP_SHIFT;
            S_SQ:    o_cmd.op = ttb_pkg::OP_SQ;
            S_SQI:   o_cmd.op = ttb_pkg::OP_SQRT_INIT;
            S_SQRT:  o_cmd.op = ttb_pkg::OP_SQRT;
            S_DVI:   o_cmd.op = ttb_pkg::OP_DIV_INIT;
            S_DIV:   o_cmd.op = ttb_pkg::OP_DIV;
            S_STORE: o_cmd.op = ttb_pkg::OP_STORE;
            default: o_cmd.op = ttb_pkg::OP_NONE;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_slot  <= 2'd0;
            r_vsel  <= 1'b0;
            r_code  <= ttb_pkg::ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (fire) begin
                        if (slot_eff == 2'd2) begin
                            r_slot  <= 2'd0;
                            r_cnt   <= '0;
                            r_state <= S_CROSS;
                        end else begin
                            r_slot <= slot_eff + 2'd1;
                        end
                    end
                end
                S_CROSS: begin
                    if (r_cnt == ttb_pkg::CNT_W'(ttb_pkg::NUM_CROSS - 1)) begin
                        r_state <= S_CWAIT;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_CWAIT: r_state <= S_DCHK;
                S_DCHK: begin
                    r_vsel <= 1'b0;
                    if (i_dstat.det_zero) begin
                        r_code  <= ttb_pkg::ST_DET_ZERO;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: r_state <= S_LEN;
                S_LEN: r_state <= S_LCHK;
                S_LCHK: begin
                    if (i_dstat.vec_zero) begin
                        r_code  <= ttb_pkg::ST_VEC_ZERO;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_cnt == ttb_pkg::CNT_W'(2)) r_state <= S_SQI;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_SQI: begin
                    r_cnt   <= ttb_pkg::CNT_W'(ttb_pkg::SQRT_STEPS - 1);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == '0) r_state <= S_DVI;
                    r_cnt <= r_cnt - 1'b1;
                end
                S_DVI: begin
                    r_cnt   <= ttb_pkg::CNT_W'(QB - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) r_state <= S_STORE;
                    r_cnt <= r_cnt - 1'b1;
                end
                S_STORE: begin
                    if (r_vsel) begin
                        r_code  <= ttb_pkg::ST_OK;
                        r_state <= S_EMIT;
                    end else begin
                        r_vsel  <= 1'b1;
                        r_state <= S_MAG;
                    end
                end
                S_EMIT: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/triangle_tangent_basis.sv */
// Triangle tangent basis: the first and second corners of a triangle are stored
// as they are taken. Once the third corner is taken, the cross products run and,
// unless a status check ends the triangle early, the one bit per cycle square
// root (32 steps) and divider (UNIT_FRAC_BITS+2 steps) run for the tangent and
// then the bitangent before the result is offered. No input is taken meanwhile.
// Synchronous active-low reset clears the corner slot, sequencer and output valid.
module triangle_tangent_basis #(
    parameter int COORD_BITS     = 16,
    parameter int UV_BITS        = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_pos_x,
    input  logic signed [COORD_BITS-1:0]      i_pos_y,
    input  logic signed [COORD_BITS-1:0]      i_pos_z,
    input  logic signed [UV_BITS-1:0]         i_tex_u,
    input  logic signed [UV_BITS-1:0]         i_tex_v,
    input  logic                              i_mesh_start,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_tangent_x,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_tangent_y,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_tangent_z,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_bitangent_x,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_bitangent_y,
    output logic signed [UNIT_FRAC_BITS+1:0]  o_bitangent_z,
    output logic [1:0]                        o_status
);

    localparam int QB = UNIT_FRAC_BITS + 2;

    ttb_pkg::t_cmd    cmd;
    ttb_pkg::t_dstat  dstat;
    ttb_pkg::t_status code;
    logic             emit;
    logic             out_free;
    logic signed [QB-1:0] tan [3];
    logic signed [QB-1:0] bit_v [3];

    logic                  r_valid;
    logic signed [QB-1:0]  r_t [3];
    logic signed [QB-1:0]  r_b [3];
    ttb_pkg::t_status      r_status;

    assign out_free = !r_valid || i_ready;

    ttb_ctrl #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mesh_start (i_mesh_start),
        .i_dstat      (dstat),
        .i_out_free   (out_free),
        .o_cmd        (cmd),
        .o_emit       (emit),
        .o_code       (code)
    );

    ttb_dpath #(
        .COORD_BITS     (COORD_BITS),
        .UV_BITS        (UV_BITS),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_tex_u (i_tex_u),
        .i_tex_v (i_tex_v),
        .o_dstat (dstat),
        .o_tan   (tan),
        .o_bit   (bit_v)
    );

    // Output register: vectors are zero unless the status is ok
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= code;
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= (code == ttb_pkg::ST_OK) ? tan[i] : '0;
                r_b[i] <= (code == ttb_pkg::ST_OK) ? bit_v[i] : '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_tangent_x   = r_t[0];
    assign o_tangent_y   = r_t[1];
    assign o_tangent_z   = r_t[2];
    assign o_bitangent_x = r_b[0];
    assign o_bitangent_y = r_b[1];
    assign o_bitangent_z = r_b[2];
    assign o_status      = r_status;

    // A good result carries two nonzero unit vectors
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ttb_pkg::ST_OK) |->
        ((o_tangent_x != 0 || o_tangent_y != 0 || o_tangent_z != 0) &&
         (o_bitangent_x != 0 || o_bitangent_y != 0 || o_bitangent_z != 0)))
        else $error("ok result with a zero vector");

    // Any failure code carries all-zero vectors
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ttb_pkg::ST_OK) |->
        (o_tangent_x == 0 && o_tangent_y == 0 && o_tangent_z == 0 &&
         o_bitangent_x == 0 && o_bitangent_y == 0 && o_bitangent_z == 0))
        else $error("failure result with nonzero vectors");

    // No input taken while the output is being produced from a third corner
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit) |-> !o_ready)
        else $error("input ready while a result is being issued");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule
